@@ hw/rtl/cmrs_pkg.sv @@
// Shared types, register map and step program of the canyon reflection solver.
package cmrs_pkg;

    localparam int CFG_ADDR_W = 5;

    localparam logic [2:0] REG_ASPECT     = 3'd0;
    localparam logic [2:0] REG_VF_SKY_RD  = 3'd1;
    localparam logic [2:0] REG_VF_WALL_RD = 3'd2;
    localparam logic [2:0] REG_VF_SKY_WL  = 3'd3;
    localparam logic [2:0] REG_VF_RD_WL   = 3'd4;
    localparam logic [2:0] REG_VF_FACING  = 3'd5;
    localparam logic [2:0] REG_PERVIOUS   = 3'd6;
    localparam logic [2:0] REG_THRESHOLD  = 3'd7;

    localparam logic [23:0] RST_ASPECT    = 24'd65536;
    localparam logic [16:0] RST_PERVIOUS  = 17'd10923;
    localparam logic [31:0] RST_THRESHOLD = 32'd2684;
    localparam logic [16:0] ONE_Q16       = 17'd65536;

    localparam logic [4:0] COMMON_LAST = 5'd20;

    typedef struct packed {
        logic [23:0] aspect;
        logic [16:0] vf_sky_road;
        logic [16:0] vf_wall_road;
        logic [16:0] vf_sky_wall;
        logic [16:0] vf_road_wall;
        logic [16:0] vf_facing;
        logic [16:0] w_per;
        logic [31:0] threshold;
    } t_cfg;

    typedef enum logic [4:0] {
        ST_NOP,
        ST_LOAD,
        ST_ABS_IMP,
        ST_ABS_PER,
        ST_ABS_SUN,
        ST_ABS_SHADE,
        ST_ACC,
        ST_REF_IMP,
        ST_REF_PER,
        ST_REF_SUN,
        ST_REF_SHADE,
        ST_R2W_A,
        ST_R2W_B,
        ST_R2W_C,
        ST_R2W_D,
        ST_S2R,
        ST_S2O,
        ST_H2R,
        ST_H2O,
        ST_SKY_IMP,
        ST_SKY_PER,
        ST_SKY_SUN,
        ST_SKY_SHADE,
        ST_SUMROAD,
        ST_ROAD,
        ST_WALLS,
        ST_RABS_IMP,
        ST_RABS_PER,
        ST_CRIT
    } t_step;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COMMON,
        S_SUM,
        S_ROAD,
        S_DIVWAIT,
        S_WALLS,
        S_RABS_IMP,
        S_RABS_PER,
        S_CRIT,
        S_CHECK,
        S_DONE
    } t_state;

    typedef struct packed {
        t_step step;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic stop;
    } t_status;

    // absorb, reflect and exchange steps shared by the first pass and each round
    function automatic t_step common_step(input logic [4:0] pc);
        t_step s;
        case (pc)
            5'd0:    s = ST_ABS_IMP;
            5'd1:    s = ST_ABS_PER;
            5'd2:    s = ST_ABS_SUN;
            5'd3:    s = ST_ABS_SHADE;
            5'd4:    s = ST_ACC;
            5'd5:    s = ST_REF_IMP;
            5'd6:    s = ST_REF_PER;
            5'd7:    s = ST_REF_SUN;
            5'd8:    s = ST_REF_SHADE;
            5'd9:    s = ST_R2W_A;
            5'd10:   s = ST_R2W_B;
            5'd11:   s = ST_R2W_C;
            5'd12:   s = ST_R2W_D;
            5'd13:   s = ST_S2R;
            5'd14:   s = ST_S2O;
            5'd15:   s = ST_H2R;
            5'd16:   s = ST_H2O;
            5'd17:   s = ST_SKY_IMP;
            5'd18:   s = ST_SKY_PER;
            5'd19:   s = ST_SKY_SUN;
            5'd20:   s = ST_SKY_SHADE;
            default: s = ST_NOP;
        endcase
        return s;
    endfunction

    function automatic logic [16:0] complement(input logic [16:0] f);
        return (f >= ONE_Q16) ? 17'd0 : ONE_Q16 - f;
    endfunction

endpackage

@@ hw/rtl/cmrs_div.sv @@
// Bit-serial restoring divider: round(x * 2^16 / h), saturating.
module cmrs_div import cmrs_pkg::*; #(
    parameter int RW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [RW-1:0] i_x,
    input  logic [23:0]   i_h,
    output logic          o_done,
    output logic [RW-1:0] o_q
);
    localparam int NW = RW + 16;
    localparam int CW = $clog2(NW + 1);
    localparam logic [RW-1:0] RAD_MAX = '1;

    logic [NW-1:0] r_num, r_q;
    logic [23:0]   r_rem, r_h;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;

    logic [24:0] rem_sh;
    logic        fits;
    logic [24:0] rem_sub;
    logic        inc;
    logic [NW:0] q_rnd;

    assign rem_sh  = {r_rem, r_num[NW-1]};
    assign fits    = rem_sh >= {1'b0, r_h};
    assign rem_sub = rem_sh - {1'b0, r_h};
    assign inc     = {r_rem, 1'b0} >= {1'b0, r_h};
    assign q_rnd   = {1'b0, r_q} + (NW+1)'(inc);
    assign o_q     = (q_rnd > (NW+1)'(RAD_MAX)) ? RAD_MAX : RW'(q_rnd);
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_x, 16'd0};
            r_h   <= (i_h == 24'd0) ? 24'd1 : i_h;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= fits ? rem_sub[23:0] : rem_sh[23:0];
            r_q   <= {r_q[NW-2:0], fits};
        end
    end

endmodule

@@ hw/rtl/cmrs_datapath.sv @@
// Datapath: working registers, one shared fraction multiplier, adders and the divider.
module cmrs_datapath import cmrs_pkg::*; #(
    parameter int RW = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_cfg        i_cfg,
    input  logic [31:0] i_road_incident,
    input  logic [31:0] i_sunwall_incident,
    input  logic [31:0] i_shadewall_incident,
    input  logic [16:0] i_albedo_impervious,
    input  logic [16:0] i_albedo_pervious,
    input  logic [16:0] i_albedo_sunwall,
    input  logic [16:0] i_albedo_shadewall,
    output t_status     o_status,
    output logic [31:0] o_abs_impervious,
    output logic [31:0] o_abs_pervious,
    output logic [31:0] o_abs_sunwall,
    output logic [31:0] o_abs_shadewall,
    output logic [31:0] o_sky_impervious,
    output logic [31:0] o_sky_pervious,
    output logic [31:0] o_sky_sunwall,
    output logic [31:0] o_sky_shadewall
);
    localparam int HW = (RW > 16) ? RW - 16 : 1;
    localparam logic [RW-1:0] RAD_MAX = '1;

    function automatic logic [RW-1:0] add_rad(input logic [RW-1:0] a, input logic [RW-1:0] b);
        logic [RW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[RW] ? RAD_MAX : s[RW-1:0];
    endfunction

    function automatic logic [RW-1:0] clip_in(input logic [31:0] v);
        return (64'(v) > 64'(RAD_MAX)) ? RAD_MAX : RW'(v);
    endfunction

    function automatic logic [31:0] out32(input logic [RW-1:0] v);
        return (64'(v) > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : 32'(v);
    endfunction

    logic [RW-1:0] r_road, r_sun, r_shade;
    logic [RW-1:0] r_abs [4];
    logic [RW-1:0] r_tabs [4];
    logic [RW-1:0] r_tsky [4];
    logic [RW-1:0] r_ref [4];
    logic [RW-1:0] r_t1, r_t2, r_r2w, r_s2r, r_s2o, r_h2r, r_h2o, r_rabs;
    logic [16:0]   r_alb [4];
    logic [16:0]   r_cmp [4];
    logic [16:0]   r_wimp, r_wper;
    logic          r_stop;

    logic [RW-1:0]  mul_x, mac_add, mul_p, mac_s;
    logic [23:0]    mul_k;
    logic [HW+15:0] xe;
    logic [HW+23:0] p_hi;
    logic [40:0]    p_lo;
    logic [HW+24:0] p_sum;
    logic           div_start, div_done;
    logic [RW-1:0]  div_q;

    always_comb begin
        mul_x   = r_road;
        mul_k   = 24'd0;
        mac_add = '0;
        case (i_cmd.step)
            ST_ABS_IMP:   begin mul_x = r_road;   mul_k = 24'(r_cmp[0]); end
            ST_ABS_PER:   begin mul_x = r_road;   mul_k = 24'(r_cmp[1]); end
            ST_ABS_SUN:   begin mul_x = r_sun;    mul_k = 24'(r_cmp[2]); end
            ST_ABS_SHADE: begin mul_x = r_shade;  mul_k = 24'(r_cmp[3]); end
            ST_REF_IMP:   begin mul_x = r_road;   mul_k = 24'(r_alb[0]); end
            ST_REF_PER:   begin mul_x = r_road;   mul_k = 24'(r_alb[1]); end
            ST_REF_SUN:   begin mul_x = r_sun;    mul_k = 24'(r_alb[2]); end
            ST_REF_SHADE: begin mul_x = r_shade;  mul_k = 24'(r_alb[3]); end
            ST_R2W_A:     begin mul_x = r_ref[0]; mul_k = 24'(i_cfg.vf_wall_road); end
            ST_R2W_B:     begin mul_x = r_t1;     mul_k = 24'(r_wimp); end
            ST_R2W_C:     begin mul_x = r_ref[1]; mul_k = 24'(i_cfg.vf_wall_road); end
            ST_R2W_D:     begin mul_x = r_t2;     mul_k = 24'(r_wper); mac_add = r_t1; end
            ST_S2R:       begin mul_x = r_ref[2]; mul_k = 24'(i_cfg.vf_road_wall); end
            ST_S2O:       begin mul_x = r_ref[2]; mul_k = 24'(i_cfg.vf_facing); end
            ST_H2R:       begin mul_x = r_ref[3]; mul_k = 24'(i_cfg.vf_road_wall); end
            ST_H2O:       begin mul_x = r_ref[3]; mul_k = 24'(i_cfg.vf_facing); end
            ST_SKY_IMP: begin
                mul_x = r_ref[0]; mul_k = 24'(i_cfg.vf_sky_road); mac_add = r_tsky[0];
            end
            ST_SKY_PER: begin
                mul_x = r_ref[1]; mul_k = 24'(i_cfg.vf_sky_road); mac_add = r_tsky[1];
            end
            ST_SKY_SUN: begin
                mul_x = r_ref[2]; mul_k = 24'(i_cfg.vf_sky_wall); mac_add = r_tsky[2];
            end
            ST_SKY_SHADE: begin
                mul_x = r_ref[3]; mul_k = 24'(i_cfg.vf_sky_wall); mac_add = r_tsky[3];
            end
            ST_ROAD:      begin mul_x = r_t1;     mul_k = i_cfg.aspect; end
            ST_RABS_IMP:  begin mul_x = r_abs[0]; mul_k = 24'(r_wimp); end
            ST_RABS_PER:  begin mul_x = r_abs[1]; mul_k = 24'(r_wper); mac_add = r_t1; end
            default: ;
        endcase
    end

    // x*k/2^16 rounded, split so the wide part stays within one multiplier
    assign xe    = (HW+16)'(mul_x);
    assign p_hi  = xe[HW+15:16] * mul_k;
    assign p_lo  = xe[15:0] * mul_k + 41'd32768;
    assign p_sum = (HW+25)'(p_hi) + (HW+25)'(p_lo[40:16]);
    assign mul_p = (p_sum > (HW+25)'(RAD_MAX)) ? RAD_MAX : RW'(p_sum);
    assign mac_s = add_rad(mac_add, mul_p);

    assign div_start = (i_cmd.step == ST_SUMROAD);

    cmrs_div #(.RW(RW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_x     (r_r2w),
        .i_h     (i_cfg.aspect),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop <= 1'b0;
        end else if (i_cmd.step == ST_LOAD) begin
            r_stop <= 1'b0;
        end else if (i_cmd.step == ST_CRIT) begin
            r_stop <= (64'(r_rabs) < 64'(i_cfg.threshold))
                   && (64'(r_abs[2]) < 64'(i_cfg.threshold))
                   && (64'(r_abs[3]) < 64'(i_cfg.threshold));
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.step)
            ST_LOAD: begin
                r_road   <= clip_in(i_road_incident);
                r_sun    <= clip_in(i_sunwall_incident);
                r_shade  <= clip_in(i_shadewall_incident);
                r_alb[0] <= i_albedo_impervious;
                r_alb[1] <= i_albedo_pervious;
                r_alb[2] <= i_albedo_sunwall;
                r_alb[3] <= i_albedo_shadewall;
                r_cmp[0] <= complement(i_albedo_impervious);
                r_cmp[1] <= complement(i_albedo_pervious);
                r_cmp[2] <= complement(i_albedo_sunwall);
                r_cmp[3] <= complement(i_albedo_shadewall);
                r_wper   <= i_cfg.w_per;
                r_wimp   <= complement(i_cfg.w_per);
                for (int i = 0; i < 4; i++) begin
                    r_tabs[i] <= '0;
                    r_tsky[i] <= '0;
                end
            end
            ST_ABS_IMP:   r_abs[0] <= mul_p;
            ST_ABS_PER:   r_abs[1] <= mul_p;
            ST_ABS_SUN:   r_abs[2] <= mul_p;
            ST_ABS_SHADE: r_abs[3] <= mul_p;
            ST_ACC: begin
                for (int i = 0; i < 4; i++) begin
                    r_tabs[i] <= add_rad(r_tabs[i], r_abs[i]);
                end
            end
            ST_REF_IMP:   r_ref[0] <= mul_p;
            ST_REF_PER:   r_ref[1] <= mul_p;
            ST_REF_SUN:   r_ref[2] <= mul_p;
            ST_REF_SHADE: r_ref[3] <= mul_p;
            ST_R2W_A:     r_t1 <= mul_p;
            ST_R2W_B:     r_t1 <= mul_p;
            ST_R2W_C:     r_t2 <= mul_p;
            ST_R2W_D:     r_r2w <= mac_s;
            ST_S2R:       r_s2r <= mul_p;
            ST_S2O:       r_s2o <= mul_p;
            ST_H2R:       r_h2r <= mul_p;
            ST_H2O:       r_h2o <= mul_p;
            ST_SKY_IMP:   r_tsky[0] <= mac_s;
            ST_SKY_PER:   r_tsky[1] <= mac_s;
            ST_SKY_SUN:   r_tsky[2] <= mac_s;
            ST_SKY_SHADE: r_tsky[3] <= mac_s;
            ST_SUMROAD:   r_t1 <= add_rad(r_s2r, r_h2r);
            ST_ROAD:      r_road <= mul_p;
            ST_WALLS: begin
                r_sun   <= add_rad(div_q, r_h2o);
                r_shade <= add_rad(div_q, r_s2o);
            end
            ST_RABS_IMP:  r_t1 <= mul_p;
            ST_RABS_PER:  r_rabs <= mac_s;
            default: ;
        endcase
    end

    assign o_status.div_done = div_done;
    assign o_status.stop     = r_stop;

    assign o_abs_impervious = out32(r_tabs[0]);
    assign o_abs_pervious   = out32(r_tabs[1]);
    assign o_abs_sunwall    = out32(r_tabs[2]);
    assign o_abs_shadewall  = out32(r_tabs[3]);
    assign o_sky_impervious = out32(r_tsky[0]);
    assign o_sky_pervious   = out32(r_tsky[1]);
    assign o_sky_sunwall    = out32(r_tsky[2]);
    assign o_sky_shadewall  = out32(r_tsky[3]);

endmodule

@@ hw/rtl/cmrs_ctrl.sv @@
// Controller: sequences the datapath steps, counts rounds and flags the result.
module cmrs_ctrl import cmrs_pkg::*; #(
    parameter int MAX_ROUNDS = 50
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_status    i_status,
    output t_cmd       o_cmd,
    output logic       o_busy,
    output logic       o_done,
    output logic [5:0] o_rounds_used
);
    localparam int RCW = $clog2(MAX_ROUNDS + 1);

    t_state         r_state, n_state;
    logic [4:0]     r_pc, n_pc;
    logic           r_in_round, n_in_round;
    logic [RCW-1:0] r_rounds, n_rounds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pc       <= '0;
            r_in_round <= 1'b0;
            r_rounds   <= '0;
        end else begin
            r_state    <= n_state;
            r_pc       <= n_pc;
            r_in_round <= n_in_round;
            r_rounds   <= n_rounds;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pc       = r_pc;
        n_in_round = r_in_round;
        n_rounds   = r_rounds;
        o_cmd.step = ST_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.step = ST_LOAD;
                    n_state    = S_COMMON;
                    n_pc       = '0;
                    n_in_round = 1'b0;
                    n_rounds   = '0;
                end
            end
            S_COMMON: begin
                o_cmd.step = common_step(r_pc);
                n_pc       = r_pc + 1'b1;
                if (r_pc == COMMON_LAST) begin
                    n_pc       = '0;
                    n_in_round = 1'b1;
                    n_state    = r_in_round ? S_RABS_IMP : S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.step = ST_SUMROAD;
                n_state    = S_ROAD;
            end
            S_ROAD: begin
                o_cmd.step = ST_ROAD;
                n_state    = S_DIVWAIT;
            end
            S_DIVWAIT: begin
                if (i_status.div_done) begin
                    n_state = S_WALLS;
                end
            end
            S_WALLS: begin
                o_cmd.step = ST_WALLS;
                n_state    = S_COMMON;
            end
            S_RABS_IMP: begin
                o_cmd.step = ST_RABS_IMP;
                n_state    = S_RABS_PER;
            end
            S_RABS_PER: begin
                o_cmd.step = ST_RABS_PER;
                n_state    = S_CRIT;
            end
            S_CRIT: begin
                o_cmd.step = ST_CRIT;
                n_rounds   = r_rounds + 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                if (!i_status.stop && (r_rounds < RCW'(MAX_ROUNDS))) begin
                    n_state = S_SUM;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = (r_state == S_DONE);
    assign o_rounds_used = (32'(r_rounds) > 32'd63) ? 6'd63 : 6'(r_rounds);

endmodule

@@ hw/rtl/canyon_multiple_reflection_solver_unit.sv @@
// Top level of the street canyon shortwave multiple reflection solver.
//
//  Channel   Direction  Handshake             Contents
//  command   in         start && !busy        three incidents, four albedos
//  result    out        o_done, one cycle     four absorbed, four sky, rounds, converged
//  config    in         APB psel/penable      eight registers at 4*index
//
// One transaction is a load and a pass of the common steps, then the rounds and the
// result; each round runs the bit-serial aspect divider and 28 other steps, 23 of
// them through the single fraction multiplier.
// Synchronous active-low reset returns the controller to idle and the configuration registers to
// their reset values. The result is shown for exactly one cycle and cannot be stalled.
module canyon_multiple_reflection_solver_unit import cmrs_pkg::*; #(
    parameter int MAX_ROUNDS = 50,
    parameter int RAD_WIDTH  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [31:0]           i_road_incident,
    input  logic [31:0]           i_sunwall_incident,
    input  logic [31:0]           i_shadewall_incident,
    input  logic [16:0]           i_albedo_impervious,
    input  logic [16:0]           i_albedo_pervious,
    input  logic [16:0]           i_albedo_sunwall,
    input  logic [16:0]           i_albedo_shadewall,
    output logic                  o_done,
    output logic [31:0]           o_abs_impervious,
    output logic [31:0]           o_abs_pervious,
    output logic [31:0]           o_abs_sunwall,
    output logic [31:0]           o_abs_shadewall,
    output logic [31:0]           o_sky_impervious,
    output logic [31:0]           o_sky_pervious,
    output logic [31:0]           o_sky_sunwall,
    output logic [31:0]           o_sky_shadewall,
    output logic [5:0]            o_rounds_used,
    output logic                  o_converged,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;
    logic    cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.aspect       <= RST_ASPECT;
            r_cfg.vf_sky_road  <= '0;
            r_cfg.vf_wall_road <= '0;
            r_cfg.vf_sky_wall  <= '0;
            r_cfg.vf_road_wall <= '0;
            r_cfg.vf_facing    <= '0;
            r_cfg.w_per        <= RST_PERVIOUS;
            r_cfg.threshold    <= RST_THRESHOLD;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ASPECT:     r_cfg.aspect       <= pwdata[23:0];
                REG_VF_SKY_RD:  r_cfg.vf_sky_road  <= pwdata[16:0];
                REG_VF_WALL_RD: r_cfg.vf_wall_road <= pwdata[16:0];
                REG_VF_SKY_WL:  r_cfg.vf_sky_wall  <= pwdata[16:0];
                REG_VF_RD_WL:   r_cfg.vf_road_wall <= pwdata[16:0];
                REG_VF_FACING:  r_cfg.vf_facing    <= pwdata[16:0];
                REG_PERVIOUS:   r_cfg.w_per        <= pwdata[16:0];
                REG_THRESHOLD:  r_cfg.threshold    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ASPECT:     prdata = 32'(r_cfg.aspect);
            REG_VF_SKY_RD:  prdata = 32'(r_cfg.vf_sky_road);
            REG_VF_WALL_RD: prdata = 32'(r_cfg.vf_wall_road);
            REG_VF_SKY_WL:  prdata = 32'(r_cfg.vf_sky_wall);
            REG_VF_RD_WL:   prdata = 32'(r_cfg.vf_road_wall);
            REG_VF_FACING:  prdata = 32'(r_cfg.vf_facing);
            REG_PERVIOUS:   prdata = 32'(r_cfg.w_per);
            REG_THRESHOLD:  prdata = r_cfg.threshold;
            default:        prdata = 32'd0;
        endcase
    end

    cmrs_ctrl #(.MAX_ROUNDS(MAX_ROUNDS)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_busy        (busy),
        .o_done        (o_done),
        .o_rounds_used (o_rounds_used)
    );

    cmrs_datapath #(.RW(RAD_WIDTH)) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_cfg                (r_cfg),
        .i_road_incident      (i_road_incident),
        .i_sunwall_incident   (i_sunwall_incident),
        .i_shadewall_incident (i_shadewall_incident),
        .i_albedo_impervious  (i_albedo_impervious),
        .i_albedo_pervious    (i_albedo_pervious),
        .i_albedo_sunwall     (i_albedo_sunwall),
        .i_albedo_shadewall   (i_albedo_shadewall),
        .o_status             (status),
        .o_abs_impervious     (o_abs_impervious),
        .o_abs_pervious       (o_abs_pervious),
        .o_abs_sunwall        (o_abs_sunwall),
        .o_abs_shadewall      (o_abs_shadewall),
        .o_sky_impervious     (o_sky_impervious),
        .o_sky_pervious       (o_sky_pervious),
        .o_sky_sunwall        (o_sky_sunwall),
        .o_sky_shadewall      (o_sky_shadewall)
    );

    assign o_converged = status.stop;

endmodule

@@ hw/rtl/cmrs_checker.sv @@
// Port-level checks of the solver's command and result timing and of the rounds count, bound to the top level.
module cmrs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [5:0] o_rounds_used
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe outside a transaction");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy && !o_done)
        else $error("busy held or strobe repeated after result");

    a_rounds_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_rounds_used != 6'd0)
        else $error("result with no reflection round");

endmodule

bind canyon_multiple_reflection_solver_unit cmrs_checker u_cmrs_checker (.*);
